// File: rtl/eps2c_pkg.sv
`timescale 1ns / 1ps

package eps2c_pkg;

   // Field widths
   localparam int SECS_W   = 32;
   localparam int OFFS_W   = 17;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DOM_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   // Working widths: local time fits 33 bits, whole days fit 17 bits
   localparam int TIME_W = SECS_W + 1;
   localparam int DAYS_W = 17;
   localparam int STEP_W = 5;

   // Time constants
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   // Quotient bits produced by each restoring-divide phase
   localparam int DAY_STEPS    = DAYS_W;
   localparam int HOUR_STEPS   = HOUR_W;
   localparam int MINUTE_STEPS = MINUTE_W;

   // Calendar constants
   localparam logic [YEAR_W-1:0] EPOCH_YEAR       = 12'd1970;
   localparam logic [6:0]        EPOCH_MOD100     = 7'd70;
   localparam logic [8:0]        EPOCH_MOD400     = 9'd370;
   localparam logic [6:0]        MOD100_LAST      = 7'd99;
   localparam logic [8:0]        MOD400_LAST      = 9'd399;
   localparam logic [8:0]        DAYS_COMMON_YEAR = 9'd365;
   localparam logic [8:0]        DAYS_LEAP_YEAR   = 9'd366;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // Handshake between the channel logic and the sequencer
   typedef struct packed {
      logic start;   // request accepted, begin conversion
      logic take;    // result moves into the output register
   } eps2c_ctrl_type;

   typedef struct packed {
      logic idle;    // ready for a new request
      logic done;    // result fields are final
   } eps2c_stat_type;

   // Days in a month, February by leap flag
   function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DOM_W-1:0] len;
      begin
         case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

// File: rtl/eps2c_cmp_sub.sv
`timescale 1ns / 1ps

// Shared compare-and-subtract: a >= b flag and a - b
module eps2c_cmp_sub (
   input  logic [eps2c_pkg::TIME_W-1:0] op_a,
   input  logic [eps2c_pkg::TIME_W-1:0] op_b,
   output logic                         ge,
   output logic [eps2c_pkg::TIME_W-1:0] diff
);
   import eps2c_pkg::*;

   logic [TIME_W:0] wide;

   // One subtractor; the borrow out is the compare
   assign wide = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = ~wide[TIME_W];
   assign diff = wide[TIME_W-1:0];

endmodule

// File: rtl/eps2c_seq.sv
`timescale 1ns / 1ps

// Sequencer: restoring divides for days / hours / minutes, then year and
// month walks, all on the one compare-subtract unit
module eps2c_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  eps2c_pkg::eps2c_ctrl_type        ctrl,
   output eps2c_pkg::eps2c_stat_type        stat,
   input  logic [eps2c_pkg::SECS_W-1:0]     unix_seconds,
   input  logic [eps2c_pkg::OFFS_W-1:0]     zone_offset_seconds,
   output logic [eps2c_pkg::YEAR_W-1:0]     year,
   output logic [eps2c_pkg::MONTH_W-1:0]    month,
   output logic [eps2c_pkg::DOM_W-1:0]      day_of_month,
   output logic [eps2c_pkg::HOUR_W-1:0]     hour,
   output logic [eps2c_pkg::MINUTE_W-1:0]   minute,
   output logic [eps2c_pkg::SECOND_W-1:0]   second
);
   import eps2c_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DAY   = 3'd1;
   localparam logic [2:0] ST_HOUR  = 3'd2;
   localparam logic [2:0] ST_MIN   = 3'd3;
   localparam logic [2:0] ST_YEAR  = 3'd4;
   localparam logic [2:0] ST_MONTH = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [DAYS_W-1:0]   days_ff, days_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [6:0]          mod100_ff, mod100_in;
   logic [8:0]          mod400_ff, mod400_in;
   logic [MONTH_W-1:0]  month_ff, month_in;

   logic [TIME_W:0]     local_sum;
   logic [TIME_W-1:0]   local_sat;
   logic                leap;
   logic [TIME_W-1:0]   op_a, op_b, diff;
   logic                ge;

   // Local time, clamped at zero when the offset drives it negative
   assign local_sum = {2'b00, unix_seconds}
                    + {{(TIME_W + 1 - OFFS_W){zone_offset_seconds[OFFS_W-1]}},
                       zone_offset_seconds};
   assign local_sat = local_sum[TIME_W] ? '0 : local_sum[TIME_W-1:0];

   // Gregorian rule from running residues of the year
   assign leap = ((year_ff[1:0] == 2'b00) && (mod100_ff != '0)) || (mod400_ff == '0);

   // Operand select for the shared unit
   always_comb begin
      op_a = rem_ff;
      op_b = '0;
      case (state_ff)
         ST_DAY:   op_b = TIME_W'(SECS_PER_DAY) << step_ff;
         ST_HOUR:  op_b = TIME_W'(SECS_PER_HOUR) << step_ff;
         ST_MIN:   op_b = TIME_W'(SECS_PER_MIN) << step_ff;
         ST_YEAR: begin
            op_a = TIME_W'(days_ff);
            op_b = TIME_W'(leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR);
         end
         ST_MONTH: begin
            op_a = TIME_W'(days_ff);
            op_b = TIME_W'(month_len(month_ff, leap));
         end
         default:  op_b = '0;
      endcase
   end

   eps2c_cmp_sub u_cmp_sub (
      .op_a (op_a),
      .op_b (op_b),
      .ge   (ge),
      .diff (diff)
   );

   // Next-state and datapath update
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      year_in   = year_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               rem_in    = local_sat;
               days_in   = '0;
               hour_in   = '0;
               minute_in = '0;
               year_in   = EPOCH_YEAR;
               mod100_in = EPOCH_MOD100;
               mod400_in = EPOCH_MOD400;
               step_in   = STEP_W'(DAY_STEPS - 1);
               state_in  = ST_DAY;
            end
         end
         ST_DAY: begin
            if (ge) rem_in = diff;
            days_in = {days_ff[DAYS_W-2:0], ge};
            if (step_ff == '0) begin
               step_in  = STEP_W'(HOUR_STEPS - 1);
               state_in = ST_HOUR;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_HOUR: begin
            if (ge) rem_in = diff;
            hour_in = {hour_ff[HOUR_W-2:0], ge};
            if (step_ff == '0) begin
               step_in  = STEP_W'(MINUTE_STEPS - 1);
               state_in = ST_MIN;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_MIN: begin
            if (ge) rem_in = diff;
            minute_in = {minute_ff[MINUTE_W-2:0], ge};
            if (step_ff == '0) begin
               state_in = ST_YEAR;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_YEAR: begin
            // one whole year per cycle
            if (ge) begin
               days_in   = diff[DAYS_W-1:0];
               year_in   = year_ff + 1'b1;
               mod100_in = (mod100_ff == MOD100_LAST) ? '0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == MOD400_LAST) ? '0 : mod400_ff + 1'b1;
            end else begin
               month_in = MONTH_JAN;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            // one whole month per cycle
            if (ge && (month_ff != MONTH_DEC)) begin
               days_in  = diff[DAYS_W-1:0];
               month_in = month_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctrl.take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
   end

   assign stat.idle    = (state_ff == ST_IDLE);
   assign stat.done    = (state_ff == ST_DONE);
   assign year         = year_ff;
   assign month        = month_ff;
   assign day_of_month = days_ff[DOM_W-1:0] + 1'b1;
   assign hour         = hour_ff;
   assign minute       = minute_ff;
   assign second       = rem_ff[SECOND_W-1:0];

   // Checks
   a_start_enters_day: assert property (@(posedge clock) disable iff (reset)
      (ctrl.start && state_ff == ST_IDLE) |=> (state_ff == ST_DAY))
      else $error("start did not enter day divide");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (month_ff >= MONTH_JAN && month_ff <= MONTH_DEC))
      else $error("month out of range during walk");

   a_residues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR) |-> (mod100_ff <= MOD100_LAST && mod400_ff <= MOD400_LAST))
      else $error("year residue counter out of range");

   a_time_of_day: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (hour_ff < 5'd24 && minute_ff < 6'd60 && rem_ff < 33'd60))
      else $error("time of day out of range");

   a_day_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (days_ff < 17'd31))
      else $error("day of month out of range");

endmodule

// File: rtl/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// req      req_valid/req_ready    req_unix_seconds[31:0], req_zone_offset_seconds[16:0]
// rsp      rsp_valid/rsp_ready    rsp_year, rsp_month, rsp_day_of_month,
//                                 rsp_hour, rsp_minute, rsp_second
//
// One request runs bit-serial divides (17 day, 5 hour, 6 minute bits), then
// a year walk from 1970, a month walk through the year and a done state,
// all on one compare-subtract unit; the next request is accepted only after
// the result has moved into the output register.
// req_ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled rsp side holds the
// finished sequencer until the register frees up.
// Reset is synchronous, active high, and clears only control state.
module epoch_seconds_to_calendar (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [eps2c_pkg::SECS_W-1:0]     req_unix_seconds,
   input  logic [eps2c_pkg::OFFS_W-1:0]     req_zone_offset_seconds,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [eps2c_pkg::YEAR_W-1:0]     rsp_year,
   output logic [eps2c_pkg::MONTH_W-1:0]    rsp_month,
   output logic [eps2c_pkg::DOM_W-1:0]      rsp_day_of_month,
   output logic [eps2c_pkg::HOUR_W-1:0]     rsp_hour,
   output logic [eps2c_pkg::MINUTE_W-1:0]   rsp_minute,
   output logic [eps2c_pkg::SECOND_W-1:0]   rsp_second
);
   import eps2c_pkg::*;

   eps2c_ctrl_type      ctrl;
   eps2c_stat_type      stat;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]   seq_year,   year_ff;
   logic [MONTH_W-1:0]  seq_month,  month_ff;
   logic [DOM_W-1:0]    seq_dom,    dom_ff;
   logic [HOUR_W-1:0]   seq_hour,   hour_ff;
   logic [MINUTE_W-1:0] seq_minute, minute_ff;
   logic [SECOND_W-1:0] seq_second, second_ff;

   // Request side
   assign req_ready  = stat.idle;
   assign ctrl.start = req_valid & stat.idle;
   // Move the result when the output register is empty or draining
   assign ctrl.take  = stat.done & (~rsp_valid_ff | rsp_ready);

   eps2c_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .stat                (stat),
      .unix_seconds        (req_unix_seconds),
      .zone_offset_seconds (req_zone_offset_seconds),
      .year                (seq_year),
      .month               (seq_month),
      .day_of_month        (seq_dom),
      .hour                (seq_hour),
      .minute              (seq_minute),
      .second              (seq_second)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         year_ff   <= seq_year;
         month_ff  <= seq_month;
         dom_ff    <= seq_dom;
         hour_ff   <= seq_hour;
         minute_ff <= seq_minute;
         second_ff <= seq_second;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = year_ff;
   assign rsp_month        = month_ff;
   assign rsp_day_of_month = dom_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;

endmodule

// File: dv/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar;
   import eps2c_pkg::*;

   localparam int RANDOM_REQS   = 1925;
   localparam int MAX_GAP       = 14;
   localparam int HOLD_AT_RSP   = 400;   // result count at which the receiver holds off
   localparam int HOLD_CYCLES   = 600;
   localparam int DRAIN_AT_A    = 700;   // request indexes where the sender waits for drain
   localparam int DRAIN_AT_B    = 1500;
   localparam int SETTLE_CYCLES = 200;   // covers the longest conversion
   localparam int STALL_LIMIT   = 4000;

   // One pending request plus the idle cycles the sender spends before it
   typedef struct {
      logic [SECS_W-1:0] secs;
      logic [OFFS_W-1:0] offs;
      int                gap;
      bit                drain;
   } stamp_req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DOM_W-1:0]    dom;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } cal_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SECS_W-1:0]   req_unix_seconds = '0;
   logic [OFFS_W-1:0]   req_zone_offset_seconds = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [YEAR_W-1:0]   rsp_year;
   logic [MONTH_W-1:0]  rsp_month;
   logic [DOM_W-1:0]    rsp_day_of_month;
   logic [HOUR_W-1:0]   rsp_hour;
   logic [MINUTE_W-1:0] rsp_minute;
   logic [SECOND_W-1:0] rsp_second;

   stamp_req_type stamp_reqs[$];
   cal_type       dates_due[$];
   stamp_req_type cur_req;
   bit            have_req = 1'b0;
   int            mismatches = 0;
   int            rsps_seen = 0;
   int            rsp_wait = 0;
   int            quiet_cycles = 0;

   epoch_seconds_to_calendar u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_unix_seconds        (req_unix_seconds),
      .req_zone_offset_seconds (req_zone_offset_seconds),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_year                (rsp_year),
      .rsp_month               (rsp_month),
      .rsp_day_of_month        (rsp_day_of_month),
      .rsp_hour                (rsp_hour),
      .rsp_minute              (rsp_minute),
      .rsp_second              (rsp_second)
   );

   always #1 clock = ~clock;

   // Gregorian rule: every 4th year, except centuries not divisible by 400
   function automatic bit leap_year(input int y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // Local calendar date and time of day for one request
   function automatic cal_type to_calendar(input logic [SECS_W-1:0] secs,
                                           input logic [OFFS_W-1:0] offs);
      longint  local_secs;
      longint  days;
      longint  sod;
      int      yr;
      int      mo;
      int      ylen;
      int      mlen;
      cal_type c;
      begin
         local_secs = longint'(secs) + longint'($signed(offs));
         if (local_secs < 0)
            local_secs = 0;
         days = local_secs / SECS_PER_DAY;
         sod  = local_secs % SECS_PER_DAY;

         // strip whole years from 1970
         yr = int'(EPOCH_YEAR);
         ylen = leap_year(yr) ? 366 : 365;
         while (days >= ylen) begin
            days -= ylen;
            yr++;
            ylen = leap_year(yr) ? 366 : 365;
         end

         // strip whole months; December takes whatever is left
         for (mo = 1; mo < 12; mo++) begin
            case (mo)
               MONTH_FEB: mlen = leap_year(yr) ? 29 : 28;
               MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: mlen = 30;
               default: mlen = 31;
            endcase
            if (days < mlen)
               break;
            days -= mlen;
         end

         c.year   = YEAR_W'(yr);
         c.month  = MONTH_W'(mo);
         c.dom    = DOM_W'(days + 1);
         c.hour   = HOUR_W'(sod / SECS_PER_HOUR);
         c.minute = MINUTE_W'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
         c.second = SECOND_W'(sod % SECS_PER_MIN);
         return c;
      end
   endfunction

   task automatic queue_req(input logic [SECS_W-1:0] secs, input logic [OFFS_W-1:0] offs,
                            input int gap, input bit drain);
      stamp_req_type r;
      begin
         r.secs  = secs;
         r.offs  = offs;
         r.gap   = gap;
         r.drain = drain;
         stamp_reqs.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // Driver: offer queued requests, predict each one as it is accepted
   always @(posedge clock) begin : driver
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         have_req = 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            dates_due.push_back(to_calendar(req_unix_seconds, req_zone_offset_seconds));
            offer = 1'b0;
         end
         if (!offer) begin
            if (!have_req && stamp_reqs.size() > 0) begin
               cur_req = stamp_reqs.pop_front();
               have_req = 1'b1;
            end
            if (have_req) begin
               if (cur_req.gap > 0) begin
                  cur_req.gap--;
               end else if (!cur_req.drain || dates_due.size() == 0) begin
                  offer = 1'b1;
                  have_req = 1'b0;
                  req_unix_seconds <= cur_req.secs;
                  req_zone_offset_seconds <= cur_req.offs;
               end
            end
         end
         req_valid <= offer;
      end
   end

   // Monitor: take results with random stalls and compare with the oldest prediction
   always @(posedge clock) begin : monitor
      logic    rdy;
      cal_type exp_cal;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         rdy = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (dates_due.size() == 0) begin
               $display("%0t: result with nothing expected, got %0d-%0d-%0d %0d:%0d:%0d",
                        $time, rsp_year, rsp_month, rsp_day_of_month,
                        rsp_hour, rsp_minute, rsp_second);
               mismatches++;
            end else begin
               exp_cal = dates_due.pop_front();
               check_field("year", exp_cal.year, rsp_year);
               check_field("month", exp_cal.month, rsp_month);
               check_field("day_of_month", exp_cal.dom, rsp_day_of_month);
               check_field("hour", exp_cal.hour, rsp_hour);
               check_field("minute", exp_cal.minute, rsp_minute);
               check_field("second", exp_cal.second, rsp_second);
            end
            rsps_seen++;
            rdy = 1'b0;
            // every fourth block of 128 results runs without stalls
            if ((rsps_seen / 128) % 4 == 1)
               rsp_wait = 0;
            else
               rsp_wait = $urandom_range(0, MAX_GAP);
            if (rsps_seen == HOLD_AT_RSP)
               rsp_wait = HOLD_CYCLES;
         end
         if (!rdy) begin
            if (rsp_wait > 0)
               rsp_wait--;
            else
               rdy = 1'b1;
         end
         rsp_ready <= rdy;
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int                n;
      int                pick;
      int                gap;
      longint            day_start;
      logic [SECS_W-1:0] secs;
      logic [OFFS_W-1:0] offs;

      // directed: epoch, saturation, offset and count extremes, leap edges
      queue_req(32'd0, 17'sd0, 0, 1'b0);
      queue_req(32'd0, -17'sd1, 0, 1'b0);
      queue_req(32'd1, -17'sd1, 3, 1'b0);
      queue_req(32'd0, 17'h10000, 0, 1'b0);
      queue_req(32'd0, 17'h0FFFF, 0, 1'b0);
      queue_req(32'd40000, -17'sd50400, 0, 1'b0);
      queue_req(32'hFFFF_FFFF, 17'h0FFFF, 0, 1'b0);
      queue_req(32'hFFFF_FFFF, 17'h10000, 5, 1'b0);
      queue_req(32'hFFFF_FFFF, 17'sd0, 0, 1'b0);
      queue_req(32'd86399, 17'sd0, 0, 1'b0);
      queue_req(32'd86400, 17'sd0, 0, 1'b0);
      queue_req(32'd31535999, 17'sd0, 0, 1'b0);      // last second of 1970
      queue_req(32'd68169600, 17'sd0, 0, 1'b0);      // 1972-02-29
      queue_req(32'd946684799, 17'sd0, 14, 1'b0);    // last second of 1999
      queue_req(32'd951782400, 17'sd0, 0, 1'b0);     // 2000-02-29, century leap year
      queue_req(32'd951868800, 17'sd0, 0, 1'b0);     // 2000-03-01
      queue_req(32'd4107542399, 17'sd0, 0, 1'b0);    // 2100-02-28 23:59:59, not leap
      queue_req(32'd4107542400, 17'sd0, 0, 1'b0);    // 2100-03-01
      queue_req(32'h7FFF_FFFF, 17'sd0, 0, 1'b0);
      queue_req(32'h8000_0000, 17'sd0, 0, 1'b0);
      queue_req(32'd1700000000, 17'sd50400, 0, 1'b0);
      queue_req(32'd1700000000, -17'sd50400, 0, 1'b0);
      queue_req(32'd946684799, 17'sd1, 0, 1'b0);     // offset carries into 2000

      // random: wide spread, day edges, and the region near zero
      for (n = 0; n < RANDOM_REQS; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            secs = $urandom();
         end else if (pick < 8) begin
            day_start = longint'($urandom_range(0, 49710)) * SECS_PER_DAY;
            case ($urandom_range(0, 2))
               0: day_start += 0;
               1: day_start += SECS_PER_DAY - 1;
               default: day_start += $urandom_range(0, SECS_PER_DAY - 1);
            endcase
            if (day_start > longint'(32'hFFFF_FFFF))
               day_start = longint'(32'hFFFF_FFFF);
            secs = SECS_W'(day_start);
         end else begin
            secs = $urandom_range(0, 70000);
         end
         if ($urandom_range(0, 9) < 7)
            offs = OFFS_W'(int'($urandom_range(0, 100800)) - 50400);
         else
            offs = OFFS_W'($urandom_range(0, 17'h1FFFF));
         // every fourth block of 128 requests goes back to back
         gap = ((n / 128) % 4 == 2) ? 0 : $urandom_range(0, MAX_GAP);
         queue_req(secs, offs, gap, (n == DRAIN_AT_A) || (n == DRAIN_AT_B));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (stamp_reqs.size() > 0 || have_req || req_valid || dates_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && dates_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
rtl/eps2c_pkg.sv
rtl/eps2c_cmp_sub.sv
rtl/eps2c_seq.sv
rtl/epoch_seconds_to_calendar.sv
dv/tb_epoch_seconds_to_calendar.sv
